[hw/rtl/sfa_pkg.sv]
// Shared types and constants for the spectral frame averager.
// Beat payload structs, controller state and command/status bundles.
// No dependencies.
package sfa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 20;
   localparam int FRAC_W   = 8;
   localparam int DVD_W    = SUM_W + FRAC_W;
   localparam int MEAN_W   = 24;
   localparam int IDX_W    = 11;
   localparam int POS_W    = 12;
   localparam int USED_W   = 5;
   localparam int LIMIT_W  = 5;
   localparam int STEP_W   = $clog2(DVD_W + 1);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic [POS_W-1:0]   POS_MAX     = '1;
   localparam logic [IDX_W-1:0]   IDX_MAX     = '1;
   localparam logic [MEAN_W-1:0]  MEAN_MAX    = '1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_pixel;
      logic                average_enable;
      logic                clear_history;
   } sfa_req_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_value;
      logic [IDX_W-1:0]  pixel_index;
      logic              frame_end;
      logic [USED_W-1:0] frames_used;
      logic              overrun;
   } sfa_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADDR,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } sfa_state_type;

   typedef struct packed {
      logic capture;
      logic clear_hist;
      logic frame_update;
      logic addr_load;
      logic mem_read;
      logic update;
      logic out_load;
   } sfa_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic will_avg;
      logic div_busy;
      logic out_free;
   } sfa_status_type;

endpackage

[hw/rtl/spectral_frame_averager_top.sv]
// Spectral frame averager: per-pixel moving average over recent frames.
// Request beats on req_* (valid/stall) carry one pixel sample each; result
// beats leave on rsp_* (valid/stall), at most one per request beat.
// A beat with clear_history set empties the history and gives no result.
// csr_write_enable/csr_write_data write the frame limit and clear history;
// write only while no beat is in flight.
// Each beat is accepted while idle, then decoded: a clear beat returns to
// idle, a pass-through or overrun pixel goes to the finish step, and an
// averaged pixel takes the address step, the registered history and sum
// memory read and write and the 28-step one-bit-per-cycle divider first.
// A result turns valid in the same cycle that the next beat can be accepted.
// The result sits in an output register, so a new beat is accepted while
// it waits; if rsp_stall holds, the next result waits in the finish step.
// Reset (synchronous) empties history and sets the limit to 16. History
// and sum memories are not cleared; entries are valid once written.
// Depends on sfa_pkg, sfa_controller, sfa_datapath, sfa_divider.
module spectral_frame_averager_top
   import sfa_pkg::*;
#(
   parameter int PIXELS     = 2048,
   parameter int MAX_FRAMES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  sfa_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfa_rsp_type        rsp_data
);

   sfa_cmd_type    cmd;
   sfa_status_type status;

   sfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfa_datapath #(
      .PIXELS     (PIXELS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

[hw/rtl/sfa_divider.sv]
// Restoring divider, one quotient bit per cycle, for the per-pixel mean.
// Depends on sfa_pkg (dividend width, step counter width).
module sfa_divider
   import sfa_pkg::*;
#(
   parameter int DIVISOR_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 busy,
   output logic [DVD_W-1:0]     quotient
);

   localparam logic [STEP_W-1:0] STEPS = STEP_W'(DVD_W);

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   assign busy     = (step_ff != '0);
   assign quotient = dvd_ff;

   // Remainder stays below the divisor, so it fits DIVISOR_W bits.
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = (trial >= {1'b0, dsr_ff});
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = STEPS;
      end else if (busy) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

[hw/rtl/sfa_datapath.sv]
// Datapath: frame bookkeeping, history ring and running-sum memories,
// sum update, divider and output register.
// Depends on sfa_pkg and sfa_divider.
module sfa_datapath
   import sfa_pkg::*;
#(
   parameter int PIXELS     = 2048,
   parameter int MAX_FRAMES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   input  sfa_req_type        req_data,
   input  sfa_cmd_type        cmd,
   output sfa_status_type     status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfa_rsp_type        rsp_data
);

   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PIX_W      = $clog2(PIXELS);
   localparam int HIST_DEPTH = MAX_FRAMES * PIXELS;
   localparam int HA_W       = $clog2(HIST_DEPTH);

   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_FRAMES - 1);
   localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
   localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_FRAMES);
   localparam logic [CNT_W:0]    SLOT_WRAP  = (CNT_W + 1)'(MAX_FRAMES);
   localparam logic [HA_W-1:0]   PIX_STRIDE = HA_W'(PIXELS);

   // frame state
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               averaging_ff, averaging_in;
   logic               dropped_ff, dropped_in;

   // item payload and address stage
   sfa_req_type        in_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [HA_W-1:0]    wr_addr_ff;
   logic [HA_W-1:0]    rd_addr_ff;
   logic [CNT_W-1:0]   cnt_eff_ff;

   logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
   logic [SUM_W-1:0]    sum_mem  [PIXELS];
   logic [SAMPLE_W-1:0] hist_rd_ff;
   logic [SUM_W-1:0]    sum_rd_ff;

   sfa_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]  lim;
   logic [CNT_W-1:0]  cnt_eff;
   logic [CNT_W:0]    slot_raw;
   logic [CNT_W:0]    slot_fix;
   logic [SLOT_W-1:0] slot;
   logic [SLOT_W-1:0] gone;
   logic [PIX_W-1:0]  pix;
   logic              over;
   logic              avg_next;
   logic              avg_path;
   logic [SUM_W-1:0]  sum_new;
   logic              div_busy;
   logic [DVD_W-1:0]  quotient;

   assign over     = (32'(pos_ff) >= PIXELS);
   assign avg_next = (pos_ff == '0) ? in_ff.average_enable : averaging_ff;
   assign avg_path = averaging_ff && !over;
   assign pix      = pos_ff[PIX_W-1:0];

   assign status.is_clear = in_ff.clear_history;
   assign status.will_avg = avg_next && !over;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // limit 0 acts as 1; above MAX_FRAMES it clamps
   always_comb begin
      if (limit_ff == '0) begin
         lim = CNT_ONE;
      end else if (32'(limit_ff) > MAX_FRAMES) begin
         lim = CNT_MAX;
      end else begin
         lim = CNT_W'(limit_ff);
      end
   end

   always_comb begin
      limit_in     = limit_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      pos_in       = pos_ff;
      averaging_in = averaging_ff;
      dropped_in   = dropped_ff;
      if (csr_write_enable) begin
         limit_in   = csr_write_data;
         count_in   = '0;
         oldest_in  = '0;
         pos_in     = '0;
         dropped_in = 1'b0;
      end else if (cmd.clear_hist) begin
         count_in   = '0;
         oldest_in  = '0;
         pos_in     = '0;
         dropped_in = 1'b0;
      end else if (cmd.frame_update && (pos_ff == '0)) begin
         averaging_in = in_ff.average_enable;
         dropped_in   = 1'b0;
         if (in_ff.average_enable) begin
            if (count_ff >= lim) begin
               dropped_in = 1'b1;
               oldest_in  = (oldest_ff == SLOT_LAST) ? '0 : SLOT_W'(oldest_ff + 1'b1);
               count_in   = lim;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end else if (cmd.out_load) begin
         if (in_ff.last_pixel) begin
            pos_in = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // ring slots: newest = oldest + count - 1, dropped = oldest - 1
   always_comb begin
      cnt_eff  = (count_ff == '0) ? CNT_ONE : count_ff;
      slot_raw = (CNT_W + 1)'(oldest_ff) + (CNT_W + 1)'(cnt_eff) - (CNT_W + 1)'(1);
      slot_fix = (slot_raw >= SLOT_WRAP) ? slot_raw - SLOT_WRAP : slot_raw;
      slot     = SLOT_W'(slot_fix);
      gone     = (oldest_ff == '0) ? SLOT_LAST : SLOT_W'(oldest_ff - 1'b1);
   end

   always_comb begin
      if (cnt_eff_ff == CNT_ONE) begin
         sum_new = SUM_W'(in_ff.sample);
      end else if (dropped_ff) begin
         sum_new = sum_rd_ff - SUM_W'(hist_rd_ff) + SUM_W'(in_ff.sample);
      end else begin
         sum_new = sum_rd_ff + SUM_W'(in_ff.sample);
      end
   end

   sfa_divider #(
      .DIVISOR_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update),
      .dividend ({sum_new, {FRAC_W{1'b0}}}),
      .divisor  (cnt_eff_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         if (avg_path) begin
            rsp_in.mean_value  = (quotient > DVD_W'(MEAN_MAX)) ? MEAN_MAX
                                                               : quotient[MEAN_W-1:0];
            rsp_in.frames_used = USED_W'(cnt_eff_ff);
         end else begin
            rsp_in.mean_value  = {in_ff.sample, {FRAC_W{1'b0}}};
            rsp_in.frames_used = '0;
         end
         rsp_in.pixel_index = (pos_ff > POS_W'(IDX_MAX)) ? IDX_MAX : pos_ff[IDX_W-1:0];
         rsp_in.frame_end   = in_ff.last_pixel;
         rsp_in.overrun     = over;
      end
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         oldest_ff    <= '0;
         pos_ff       <= '0;
         averaging_ff <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         pos_ff       <= pos_in;
         averaging_ff <= averaging_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         in_ff <= req_data;
      end
      if (cmd.addr_load) begin
         pix_ff     <= pix;
         wr_addr_ff <= HA_W'(HA_W'(slot) * PIX_STRIDE + HA_W'(pix));
         rd_addr_ff <= HA_W'(HA_W'(gone) * PIX_STRIDE + HA_W'(pix));
         cnt_eff_ff <= cnt_eff;
      end
   end

   // history ring: read the dropped frame's sample, then write the new one
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         hist_rd_ff <= hist_mem[rd_addr_ff];
      end
      if (cmd.update) begin
         hist_mem[wr_addr_ff] <= in_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         sum_rd_ff <= sum_mem[pix_ff];
      end
      if (cmd.update) begin
         sum_mem[pix_ff] <= sum_new;
      end
   end

endmodule

[hw/rtl/sfa_controller.sv]
// Controller state machine: decodes a beat, then for averaged pixels memory
// access, sum update, division; output load for all but clear beats. Depends on sfa_pkg.
module sfa_controller
   import sfa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  sfa_status_type status,
   output sfa_cmd_type    cmd
);

   sfa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_clear) begin
               state_in = ST_IDLE;
            end else if (status.will_avg) begin
               state_in = ST_ADDR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.clear_hist   = status.is_clear;
            cmd.frame_update = !status.is_clear;
         end
         ST_ADDR: begin
            cmd.addr_load = 1'b1;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_DIVIDE: begin
            cmd = '0;
         end
         ST_FINISH: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
